// ===== hdl/strip_chart_autoscale_assert.svh =====
// Assertion macros used by the checker file.
// Each macro expects clk and rst in scope.
`ifndef STRIP_CHART_AUTOSCALE_ASSERT_SVH
`define STRIP_CHART_AUTOSCALE_ASSERT_SVH

// Consequent must hold at the same edge as the antecedent.
`define SCA_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("strip chart check failed");

// Consequent must hold at the edge after the antecedent.
`define SCA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("strip chart check failed");

`endif

// ===== hdl/sca_pkg.sv =====
`default_nettype none

package sca_pkg;

  localparam int GRAPHS = 4;
  localparam int LINES  = 256;

  localparam int G_W   = (GRAPHS > 1) ? $clog2(GRAPHS) : 1;
  localparam int L_W   = $clog2(LINES);
  localparam int A_W   = $clog2(GRAPHS * LINES);
  localparam int SUM_W = 32 + ((GRAPHS > 1) ? $clog2(GRAPHS) : 0);

  localparam int SCALE_W   = 40;
  localparam int FIXED_W   = 31;
  localparam int WIN_W     = 13;
  localparam int CFG_IDX_W = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_SCALE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_COLUMNS = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_LIMIT    = CFG_IDX_W'(2);

  localparam logic [FIXED_W-1:0] FIXED_SCALE_RST = FIXED_W'(1);
  localparam logic [WIN_W-1:0]   WINDOW_RST      = WIN_W'(32);
  localparam logic [SCALE_W-1:0] LIMIT_RST       = SCALE_W'(64'd1 << 30);

  typedef struct packed {
    logic [3:0]         graph_index;
    logic signed [31:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic [SCALE_W-1:0] scale_out;
    logic               rejected;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;         // capture the input item
    logic wr_hist;      // append the sample to its graph
    logic scan_start;   // clear window counters, maximum and candidate scale
    logic rd_issue;     // read one history entry
    logic dec_step;     // multiply the candidate scale by ten
    logic scale_auto;   // take the candidate scale
    logic scale_fixed;  // take the fixed scale
    logic out_load;     // load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic bad;          // captured graph index out of range
    logic autoscale;    // fixed scale is zero
    logic win_zero;     // clamped window is empty
    logic scan_last;    // current read is the last of the window
    logic dec_done;     // candidate scale reached maximum or limit
    logic out_free;     // result register can take a new item
  } sts_t;

endpackage

`default_nettype wire

// ===== hdl/sca_ctrl.sv =====
`default_nettype none

module sca_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sca_pkg::sts_t sts,
  output sca_pkg::cmd_t cmd
);
  import sca_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_WRITE  = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_DRAIN  = 6'b001000,
    ST_DECADE = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (sts.bad) begin
          state_next = ST_DONE;
        end else begin
          cmd.wr_hist    = 1'b1;
          cmd.scan_start = 1'b1;
          if (!sts.autoscale) begin
            cmd.scale_fixed = 1'b1;
            state_next      = ST_DONE;
          end else if (sts.win_zero) begin
            state_next = ST_DECADE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.rd_issue = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DECADE;
      end
      ST_DECADE: begin
        if (sts.dec_done) begin
          cmd.scale_auto = 1'b1;
          state_next     = ST_DONE;
        end else begin
          cmd.dec_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/sca_dpath.sv =====
`default_nettype none

module sca_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  sca_pkg::in_item_t                   in_data,
  input  logic                                cfg_we,
  input  logic [sca_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sca_pkg::SCALE_W-1:0]         cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sca_pkg::out_item_t                  out_data,
  input  sca_pkg::cmd_t                       cmd,
  output sca_pkg::sts_t                       sts
);
  import sca_pkg::*;

  // Configuration
  logic [FIXED_W-1:0] fixed_scale;
  logic [WIN_W-1:0]   window_columns;
  logic [SCALE_W-1:0] scale_limit;
  logic [SCALE_W-1:0] scale_now;

  // Captured item
  in_item_t item;
  logic     item_bad;
  logic [G_W-1:0] item_g;

  // History store and per-graph fill tracking
  logic signed [31:0] mem [GRAPHS*LINES];
  logic [L_W-1:0]     ptr [GRAPHS];
  logic [GRAPHS-1:0]  full;

  // Window scan
  logic [L_W-1:0]     kc;
  logic [G_W-1:0]     sg;
  logic [WIN_W-1:0]   win_eff;
  logic [G_W-1:0]     pg;
  logic [L_W-1:0]     ptr_cur;
  logic [L_W-1:0]     wr_pos;
  logic [L_W-1:0]     rd_pos;
  logic [L_W-1:0]     mem_pos;
  logic [A_W-1:0]     addr;
  logic               rd_ok;

  // Read pipeline and column sums
  logic               rd_v;
  logic [G_W-1:0]     rd_g;
  logic               rd_ok_q;
  logic signed [31:0] rd_data;
  logic signed [SUM_W-1:0] data_ext;
  logic signed [SUM_W-1:0] acc;
  logic signed [SUM_W-1:0] col;
  logic signed [SUM_W-1:0] maxv;
  logic [SCALE_W-1:0] max_ext;
  logic [SCALE_W-1:0] cand;

  assign item_bad = {1'b0, item.graph_index} >= 5'(GRAPHS);
  assign item_g   = item.graph_index[G_W-1:0];

  always_comb begin
    win_eff = (window_columns > WIN_W'(LINES)) ? WIN_W'(LINES) : window_columns;
    pg      = cmd.wr_hist ? item_g : sg;
    ptr_cur = ptr[pg];
    wr_pos  = (ptr_cur == L_W'(LINES - 1)) ? '0 : ptr_cur + L_W'(1);
    if (kc <= ptr_cur) begin
      rd_pos = ptr_cur - kc;
    end else begin
      rd_pos = L_W'({1'b0, ptr_cur} + (L_W+1)'(LINES) - {1'b0, kc});
    end
    // Entries never written read as zero
    rd_ok   = full[pg] || ((rd_pos != '0) && (rd_pos <= ptr_cur));
    mem_pos = cmd.wr_hist ? wr_pos : rd_pos;
    addr    = A_W'(pg) * A_W'(LINES) + A_W'(mem_pos);
  end

  always_comb begin
    data_ext = rd_ok_q ? SUM_W'(rd_data) : '0;
    col      = ((rd_g == '0) ? '0 : acc) + data_ext;
    max_ext  = SCALE_W'(maxv);
  end

  assign sts.bad       = item_bad;
  assign sts.autoscale = (fixed_scale == '0);
  assign sts.win_zero  = (win_eff == '0);
  assign sts.scan_last = (WIN_W'(kc) == win_eff - WIN_W'(1)) && (sg == G_W'(GRAPHS - 1));
  assign sts.dec_done  = !((cand < max_ext) && (cand < scale_limit));
  assign sts.out_free  = !out_valid || out_ready;

  // Configuration registers and current scale
  always_ff @(posedge clk) begin
    if (rst) begin
      fixed_scale    <= FIXED_SCALE_RST;
      window_columns <= WINDOW_RST;
      scale_limit    <= LIMIT_RST;
      scale_now      <= SCALE_W'(FIXED_SCALE_RST);
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FIXED_SCALE: begin
            fixed_scale <= cfg_data[FIXED_W-1:0];
            if (cfg_data[FIXED_W-1:0] != '0) begin
              scale_now <= SCALE_W'(cfg_data[FIXED_W-1:0]);
            end
          end
          CFG_WINDOW_COLUMNS: window_columns <= cfg_data[WIN_W-1:0];
          CFG_SCALE_LIMIT:    scale_limit    <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.scale_fixed) begin
        scale_now <= SCALE_W'(fixed_scale);
      end else if (cmd.scale_auto) begin
        scale_now <= cand;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_data;
    end
  end

  // Pointers and fill flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < GRAPHS; i++) begin
        ptr[i] <= '0;
      end
      full <= '0;
    end else if (cmd.wr_hist) begin
      ptr[item_g] <= wr_pos;
      if (wr_pos == '0) begin
        full[item_g] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_hist) begin
      mem[addr] <= item.sample_value;
    end
    if (cmd.rd_issue) begin
      rd_data <= mem[addr];
    end
  end

  // Scan counters: graph is the inner loop
  always_ff @(posedge clk) begin
    if (rst) begin
      kc   <= '0;
      sg   <= '0;
      rd_v <= 1'b0;
    end else begin
      rd_v <= cmd.rd_issue;
      if (cmd.scan_start) begin
        kc <= '0;
        sg <= '0;
      end else if (cmd.rd_issue) begin
        if (sg == G_W'(GRAPHS - 1)) begin
          sg <= '0;
          kc <= kc + L_W'(1);
        end else begin
          sg <= sg + G_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_g    <= sg;
      rd_ok_q <= rd_ok;
    end
  end

  // Column sums, running maximum floored at zero, decade search
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      maxv <= '0;
      cand <= SCALE_W'(1);
    end else begin
      if (rd_v) begin
        acc <= col;
        if ((rd_g == G_W'(GRAPHS - 1)) && (col > maxv)) begin
          maxv <= col;
        end
      end
      if (cmd.dec_step) begin
        cand <= (cand << 3) + (cand << 1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.scale_out <= scale_now;
      out_data.rejected  <= item_bad;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/strip_chart_autoscale.sv =====
// Channel   Signals                          Direction  Moves
// in        in_valid in_ready in_data        into block one sample item
// out       out_valid out_ready out_data     out of     one scale item
// cfg       cfg_valid cfg_ready cfg_index    into block one register write
//           cfg_data
//
// After an accept, a rejected item or a fixed scale goes to the result load;
// with autoscale the block writes the sample, reads GRAPHS*W entries (W the
// clamped window), drains the last read and takes D decade steps (at most ten,
// since stacked sums stay below 10^10) before the result load.
// The scan is bound by the single read port of the history store.
// One item is in work at a time; in_ready is high only while idle.
// The result register lets the next item in while a result waits; a stalled
// output holds the controller before it loads the next result.
// rst is synchronous; history needs no clearing pass, unfilled entries
// read as zero through per-graph fill flags. cfg_ready is always high.
`default_nettype none

module strip_chart_autoscale (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sca_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sca_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sca_pkg::SCALE_W-1:0]   cfg_data
);
  import sca_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Registers are always writable; writes must come only while idle (not enforced)
  assign cfg_ready = 1'b1;

  // Controller: sequences write, window scan, drain, decade search and
  // result load
  sca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: history store, column sums, maximum, scale and result register
  sca_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

// ===== hdl/sca_checker.sv =====
`default_nettype none

`include "strip_chart_autoscale_assert.svh"

module sca_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input sca_pkg::out_item_t            out_data
);
  import sca_pkg::*;

  // One item at a time: input closes right after an accept
  `SCA_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

  // A new result appears only as the block returns from work
  `SCA_ASSERT_NOW(a_result_from_work, $rose(out_valid), $past(!in_ready))

  // Scale is never zero
  `SCA_ASSERT_NOW(a_scale_nonzero, out_valid, out_data.scale_out != '0)

  // A stalled result holds
  `SCA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind strip_chart_autoscale sca_checker u_sca_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== tb/tb_strip_chart_autoscale.sv =====
module tb_strip_chart_autoscale;
  import sca_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int TIMEOUT_CYCLES = 2_000_000;
  // Longest autoscale pass in the last phase is well under this.
  localparam int TAIL_CYCLES    = 300;
  localparam int HOLDOFF_CYCLES = 400;

  // Index 3 decodes to no register; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = CFG_IDX_W'(3);
  localparam logic [SCALE_W-1:0]   MAX_LIMIT      = SCALE_W'(64'd1_000_000_000_000);

  logic clk;
  logic rst = 1'b1;

  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FIXED_SCALE;
  logic [SCALE_W-1:0]   cfg_data  = '0;

  strip_chart_autoscale u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Sample items waiting to be offered, and scale items still owed by the block.
  in_item_t  sample_backlog[$];
  out_item_t expected_scales[$];
  out_item_t oldest_scale;
  int        mismatch_count = 0;

  // Idle rates in percent per cycle, and the request for a long output hold-off.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_epoch   = 0;
  int stall_seen;
  int stall_left;

  // Chart mirror: per-graph sample rings, newest positions, registers, scale.
  logic signed [31:0] chart_hist [GRAPHS][LINES];
  int unsigned        newest_pos [GRAPHS];
  logic [FIXED_W-1:0] fixed_reg;
  logic [WIN_W-1:0]   window_reg;
  logic [SCALE_W-1:0] limit_reg;
  logic [SCALE_W-1:0] scale_cur;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Mirror a register write; a nonzero fixed scale takes effect at once,
  // while a zero one waits for the next accepted sample.
  function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                          logic [SCALE_W-1:0] value);
    case (idx)
      CFG_FIXED_SCALE: begin
        fixed_reg = value[FIXED_W-1:0];
        if (value[FIXED_W-1:0] != '0) scale_cur = SCALE_W'(value[FIXED_W-1:0]);
      end
      CFG_WINDOW_COLUMNS: window_reg = value[WIN_W-1:0];
      CFG_SCALE_LIMIT:    limit_reg  = value;
      default: ;
    endcase
  endfunction

  // Append one sample and work out the scale item the block must return.
  function automatic out_item_t predict_scale(in_item_t it);
    out_item_t   res;
    int unsigned g, span, idx;
    longint      col_sum, peak;
    longint unsigned cand;
    g = it.graph_index;
    res.rejected = 1'b0;
    if (g >= GRAPHS) begin
      // Drop the sample; report the held scale.
      res.scale_out = scale_cur;
      res.rejected  = 1'b1;
      return res;
    end
    newest_pos[g] = (newest_pos[g] + 1) % LINES;
    chart_hist[g][newest_pos[g]] = it.sample_value;
    if (fixed_reg != '0) begin
      scale_cur = SCALE_W'(fixed_reg);
    end else begin
      // Stack all graphs at each of the newest window positions, exactly.
      span = (window_reg > LINES) ? LINES : window_reg;
      peak = 0;
      for (int unsigned k = 0; k < span; k++) begin
        col_sum = 0;
        for (int gg = 0; gg < GRAPHS; gg++) begin
          idx = (newest_pos[gg] + LINES - k) % LINES;
          col_sum += chart_hist[gg][idx];
        end
        if (col_sum > peak) peak = col_sum;
      end
      // Climb decades until the peak or the limit is reached.
      cand = 1;
      while (cand < longint'(peak) && cand < limit_reg) cand *= 10;
      scale_cur = cand[SCALE_W-1:0];
    end
    res.scale_out = scale_cur;
    return res;
  endfunction

  // Driver: offer the next backlog item when the slot is free, idling at random.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= sample_backlog.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: hold off for a long stretch on request, else stall at random.
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_seen <= 0;
      stall_left <= 0;
    end else if (stall_seen != stall_epoch) begin
      stall_seen <= stall_epoch;
      stall_left <= HOLDOFF_CYCLES;
      out_ready  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: check each result item against the oldest expectation first, then
  // mirror register writes and accepted samples.
  always @(posedge clk) begin
    if (rst) begin
      for (int gg = 0; gg < GRAPHS; gg++) begin
        newest_pos[gg] = 0;
        for (int li = 0; li < LINES; li++) chart_hist[gg][li] = '0;
      end
      fixed_reg  = FIXED_SCALE_RST;
      window_reg = WINDOW_RST;
      limit_reg  = LIMIT_RST;
      scale_cur  = SCALE_W'(FIXED_SCALE_RST);
      expected_scales.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_scales.size() == 0) begin
          $error("unexpected result item: scale_out %0d rejected %0b",
                 out_data.scale_out, out_data.rejected);
          mismatch_count++;
        end else begin
          oldest_scale = expected_scales.pop_front();
          if (out_data.scale_out !== oldest_scale.scale_out) begin
            $error("scale_out: expected %0d, got %0d",
                   oldest_scale.scale_out, out_data.scale_out);
            mismatch_count++;
          end
          if (out_data.rejected !== oldest_scale.rejected) begin
            $error("rejected: expected %0b, got %0b",
                   oldest_scale.rejected, out_data.rejected);
            mismatch_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) apply_reg_write(cfg_index, cfg_data);
      if (in_valid && in_ready) expected_scales.push_back(predict_scale(in_data));
    end
  end

  task automatic queue_sample(input logic [3:0] g, input logic [31:0] v);
    in_item_t it;
    it.graph_index  = g;
    it.sample_value = v;
    sample_backlog.push_back(it);
  endtask

  // Mostly valid graphs; values spread over decades, noise and the extremes.
  function automatic in_item_t random_sample();
    in_item_t it;
    if ($urandom_range(99) < 88) it.graph_index = 4'($urandom_range(GRAPHS - 1));
    else                         it.graph_index = 4'($urandom_range(15, GRAPHS));
    case ($urandom_range(3))
      0: it.sample_value = $urandom;
      1: it.sample_value = $urandom_range(10 ** $urandom_range(9));
      2: it.sample_value = -$signed($urandom_range(5000));
      default: begin
        case ($urandom_range(3))
          0:       it.sample_value = 32'h7FFF_FFFF;
          1:       it.sample_value = 32'h8000_0000;
          2:       it.sample_value = 32'h0000_0000;
          default: it.sample_value = 32'hFFFF_FFFF;
        endcase
      end
    endcase
    return it;
  endfunction

  // Wait until nothing is queued, offered or owed; sample at the falling edge
  // so the check never races the clocked processes.
  task automatic wait_idle();
    do @(negedge clk);
    while (sample_backlog.size() != 0 || in_valid || expected_scales.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [SCALE_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Program all three registers while idle (junk above the fixed and window fields),
  // then send random items in two halves with a full drain between them.
  task automatic run_phase(input logic [FIXED_W-1:0] fixed_v,
                           input logic [WIN_W-1:0]   window_v,
                           input logic [SCALE_W-1:0] limit_v,
                           input int                 n_items,
                           input bit                 long_stall);
    wait_idle();
    write_reg(CFG_FIXED_SCALE,    {9'($urandom), fixed_v});
    write_reg(CFG_WINDOW_COLUMNS, {27'($urandom), window_v});
    write_reg(CFG_SCALE_LIMIT,    limit_v);
    for (int i = 0; i < n_items / 2; i++) sample_backlog.push_back(random_sample());
    if (long_stall) begin
      // Block the output while the sender keeps offering, so the block fills.
      @(negedge clk);
      stall_epoch++;
    end
    wait_idle();
    for (int i = n_items / 2; i < n_items; i++) sample_backlog.push_back(random_sample());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed items, sender idling lightly and receiver heavily.
    send_idle_pct = 22;
    recv_idle_pct = 82;

    // Reset settings: fixed scale of one, field extremes, out-of-range graphs.
    queue_sample(4'd0, 32'h7FFF_FFFF);
    queue_sample(4'(GRAPHS - 1), 32'h8000_0000);
    queue_sample(4'(GRAPHS), 32'h0000_0000);
    queue_sample(4'd15, 32'hFFFF_FFFF);
    queue_sample(4'd1, 32'h0000_0000);
    wait_idle();

    // A nonzero fixed scale shows up at once, even on a rejected item.
    write_reg(CFG_FIXED_SCALE, SCALE_W'(7));
    queue_sample(4'd15, 32'h0000_1234);
    wait_idle();

    // Zero after masking turns autoscale on but holds the scale until the next
    // accepted sample; oversize window clamps to the history length.
    write_reg(CFG_FIXED_SCALE, 40'hFF_8000_0000);
    write_reg(CFG_WINDOW_COLUMNS, 40'hAB_CDE0_1FFF);
    write_reg(CFG_SCALE_LIMIT, MAX_LIMIT);
    queue_sample(4'd9, 32'h0000_0005);
    // Stack the largest positives on every graph (sum beyond 32 bits), then
    // the most negative values.
    for (int g = 0; g < GRAPHS; g++) queue_sample(4'(g), 32'h7FFF_FFFF);
    for (int g = 0; g < GRAPHS; g++) queue_sample(4'(g), 32'h8000_0000);
    wait_idle();

    // Empty window: nothing examined, scale of one.
    write_reg(CFG_WINDOW_COLUMNS, SCALE_W'(0));
    queue_sample(4'd1, 32'd5);
    wait_idle();

    // Zero limit: scale never leaves one.
    write_reg(CFG_WINDOW_COLUMNS, SCALE_W'(1));
    write_reg(CFG_SCALE_LIMIT, SCALE_W'(0));
    queue_sample(4'd2, 32'h7FFF_FFFF);
    wait_idle();

    // Writes to the unused index must leave every register alone.
    write_reg(CFG_UNUSED_IDX, 40'hFF_FFFF_FFFF);
    write_reg(CFG_SCALE_LIMIT, SCALE_W'(1000));
    queue_sample(4'd0, 32'd999_999);
    queue_sample(4'd3, -32'sd5);

    // Random phases, first idling mode.
    run_phase(FIXED_W'(0), WIN_W'(1), LIMIT_RST, 120, 1'b0);
    run_phase(FIXED_W'($urandom_range(32'h7FFF_FFFF, 1)), WIN_W'($urandom_range(64, 1)),
              SCALE_W'($urandom), 120, 1'b1);
    run_phase(FIXED_W'(0), WIN_W'(8), MAX_LIMIT, 120, 1'b0);

    // Swap: sender idles heavily, receiver lightly.
    send_idle_pct = 82;
    recv_idle_pct = 22;
    run_phase(FIXED_W'(0), WINDOW_RST, SCALE_W'(0), 100, 1'b0);
    run_phase(FIXED_W'(0), WIN_W'(0), LIMIT_RST, 80, 1'b0);
    run_phase(FIXED_W'(32'h7FFF_FFFF), WINDOW_RST, LIMIT_RST, 100, 1'b0);
    // Full-depth scans are slow; keep this phase short.
    run_phase(FIXED_W'(0), WIN_W'(4096), MAX_LIMIT, 20, 1'b0);

    // No idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(FIXED_W'(0), WIN_W'($urandom_range(40, 1)),
              {8'($urandom_range(232)), 32'($urandom)}, 150, 1'b0);
    run_phase(FIXED_W'(0), WIN_W'(3), SCALE_W'(1), 100, 1'b0);
    run_phase(FIXED_W'(0), WIN_W'(17), SCALE_W'(64'd10 ** $urandom_range(12)), 150, 1'b0);

    // Drain, then watch a while longer for stray result items.
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_scales.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: give up if the run hangs.
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("FAILURE");
    $finish;
  end

endmodule
